/* design/pjs_pkg.sv */
// shared constants, codes and types of the priority job scheduler
package pjs_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int ID_W        = 16;
	localparam int PRIO_W      = 8;
	localparam int TIME_W      = 16;
	localparam int SEQ_W       = 16;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_RUNNING  = 2'd2,
		ST_IDLE     = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ARRIVAL = 1'b0,
		CMD_TICK    = 1'b1
	} cmd_t;

	// best-so-far record handed from cell to cell during a scan
	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [SEQ_W-1:0]  age;
		logic [IDX_W-1:0]  slot;
	} cand_t;

	// table control broadcast to every cell
	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_slot;
		logic [ID_W-1:0]   wr_id;
		logic [PRIO_W-1:0] wr_prio;
		logic [TIME_W-1:0] wr_rem;
		logic [SEQ_W-1:0]  wr_seq;
		logic              run_en;
		logic [IDX_W-1:0]  sel;
	} cell_ctl_t;

	// read-back of the selected cell, zero from every other cell
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            last;
	} cell_rd_t;

endpackage

/* design/priority_job_scheduler.sv */
// top level of the priority job scheduler: control and the row of slot cells
//
// requests come in on start with cmd, job_id, job_priority and exec_time and are
// taken at an edge where start is high and busy is low. every request gives one
// result on status, running_id and job_done, marked by result_valid for a single
// cycle; the receiver cannot hold results off, so nothing ever waits on it.
// an arrival request: the lowest free slot is found and written at the
// accepting edge and the result shows in the next cycle, busy stays low.
// a tick request: a best-so-far record walks the row of cells one slot per
// cycle, and busy is high until the result cycle. the scan length is set
// by the cell chain, one cell per cycle.
// preempt_enable is written on the cfg channel (cfg_valid, cfg_ready, cfg_data),
// always ready; it is meant to change only while the block is idle.
// asynchronous reset empties the table, idles the processor, clears the arrival
// counter and sets preempt_enable to 1; slot payload is left as it was.
module priority_job_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cmd,
	input  logic [pjs_pkg::ID_W-1:0]          job_id,
	input  logic [pjs_pkg::PRIO_W-1:0]        job_priority,
	input  logic [pjs_pkg::TIME_W-1:0]        exec_time,
	output logic                              result_valid,
	output logic [1:0]                        status,
	output logic [pjs_pkg::ID_W-1:0]          running_id,
	output logic                              job_done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data
);

	localparam int DEPTH = pjs_pkg::TABLE_DEPTH;
	localparam int IW    = pjs_pkg::IDX_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                          state_q;
	logic [IW-1:0]                   cnt_q;
	logic                            preempt_q;
	logic [pjs_pkg::SEQ_W-1:0]       arr_cnt_q;
	logic [IW-1:0]                   run_slot_q;
	logic                            run_valid_q;
	logic [pjs_pkg::PRIO_W-1:0]      run_prio_q;
	logic                            res_valid_q;
	logic [1:0]                      status_q;
	logic [pjs_pkg::ID_W-1:0]        res_id_q;
	logic                            res_done_q;

	pjs_pkg::cand_t                  chain [DEPTH+1];
	logic [DEPTH-1:0]                valid_vec;
	pjs_pkg::cell_rd_t               rd_vec [DEPTH];
	pjs_pkg::cell_rd_t               rd_sel;
	pjs_pkg::cell_ctl_t              ctl;

	logic                            accept;
	logic                            free_found;
	logic [IW-1:0]                   free_slot;
	logic                            scan_end;
	logic                            run_live;
	logic                            take_best;
	logic                            do_run;
	pjs_pkg::cand_t                  best;

	assign accept    = start && !busy;
	assign busy      = (state_q == S_SCAN);
	assign cfg_ready = 1'b1;
	assign scan_end  = (state_q == S_SCAN) && (cnt_q == IW'(DEPTH-1));
	assign best      = chain[DEPTH];

	// head of the chain starts every scan with an empty record
	assign chain[0] = '0;

	generate
		for (genvar g = 0; g < DEPTH; g++) begin : g_cell
			pjs_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (IW'(g)),
				.ctl      (ctl),
				.arr_cnt  (arr_cnt_q),
				.cand_in  (chain[g]),
				.cand_out (chain[g+1]),
				.valid    (valid_vec[g]),
				.rd       (rd_vec[g])
			);
		end
	endgenerate

	// lowest free slot for an arrival
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = DEPTH-1; i >= 0; i--) begin
			if (!valid_vec[i]) begin
				free_found = 1'b1;
				free_slot  = IW'(i);
			end
		end
	end

	// only the selected cell drives its read-back, the rest give zero
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < DEPTH; i++)
			rd_sel = rd_sel | rd_vec[i];
	end

	// tick decision at the end of the scan
	// a running slot that is no longer valid counts as an idle processor
	always_comb begin
		run_live  = run_valid_q && valid_vec[run_slot_q];
		take_best = 1'b0;
		do_run    = 1'b0;
		if (!run_live) begin
			take_best = best.valid;
			do_run    = best.valid;
		end else begin
			do_run = 1'b1;
			// equal priority never displaces the running job
			take_best = preempt_q && best.valid && (best.prio < run_prio_q);
		end
	end

	always_comb begin
		ctl         = '0;
		ctl.wr_en   = accept && (cmd == pjs_pkg::CMD_ARRIVAL) && free_found;
		ctl.wr_slot = free_slot;
		ctl.wr_id   = job_id;
		ctl.wr_prio = job_priority;
		// a zero length counts as one tick
		ctl.wr_rem  = (exec_time == '0) ? pjs_pkg::TIME_W'(1) : exec_time;
		ctl.wr_seq  = arr_cnt_q;
		ctl.run_en  = scan_end && do_run;
		ctl.sel     = take_best ? best.slot : run_slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			preempt_q   <= 1'b1;
			arr_cnt_q   <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				preempt_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == pjs_pkg::CMD_TICK) begin
							state_q <= S_SCAN;
							cnt_q   <= '0;
						end else begin
							res_valid_q <= 1'b1;
							if (free_found)
								arr_cnt_q <= arr_cnt_q + pjs_pkg::SEQ_W'(1);
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + IW'(1);
					if (scan_end) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b1;
						if (!do_run) begin
							run_valid_q <= 1'b0;
						end else begin
							run_slot_q  <= ctl.sel;
							run_valid_q <= !rd_sel.last;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload and the priority of the job on the processor
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && cmd == pjs_pkg::CMD_ARRIVAL) begin
			status_q   <= free_found ? pjs_pkg::ST_ACCEPTED : pjs_pkg::ST_FULL;
			res_id_q   <= '0;
			res_done_q <= 1'b0;
		end else if (scan_end) begin
			if (do_run) begin
				status_q   <= pjs_pkg::ST_RUNNING;
				res_id_q   <= rd_sel.id;
				res_done_q <= rd_sel.last;
			end else begin
				status_q   <= pjs_pkg::ST_IDLE;
				res_id_q   <= '0;
				res_done_q <= 1'b0;
			end
			if (take_best)
				run_prio_q <= best.prio;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign running_id   = res_id_q;
	assign job_done     = res_done_q;

endmodule

/* design/pjs_cell.sv */
// one job slot of the table, with its stage of the urgency scan chain
module pjs_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pjs_pkg::IDX_W-1:0]     idx,
	input  pjs_pkg::cell_ctl_t            ctl,
	input  logic [pjs_pkg::SEQ_W-1:0]     arr_cnt,
	input  pjs_pkg::cand_t                cand_in,
	output pjs_pkg::cand_t                cand_out,
	output logic                          valid,
	output pjs_pkg::cell_rd_t             rd
);

	logic                           valid_q;
	logic [pjs_pkg::ID_W-1:0]       id_q;
	logic [pjs_pkg::PRIO_W-1:0]     prio_q;
	logic [pjs_pkg::TIME_W-1:0]     rem_q;
	logic [pjs_pkg::SEQ_W-1:0]      seq_q;
	pjs_pkg::cand_t                 cand_q;
	logic [pjs_pkg::SEQ_W-1:0]      age;
	logic                           wins;
	logic                           hit;
	logic                           last;

	assign age  = arr_cnt - seq_q;
	assign hit  = (ctl.sel == idx);
	assign last = (rem_q == pjs_pkg::TIME_W'(1));

	// strictly more urgent than the record so far: lower number, or older on a tie
	always_comb begin
		wins = 1'b0;
		if (valid_q) begin
			if (!cand_in.valid)
				wins = 1'b1;
			else if (prio_q < cand_in.prio)
				wins = 1'b1;
			else if (prio_q == cand_in.prio && age > cand_in.age)
				wins = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= '0;
		end else begin
			if (wins) begin
				cand_q.valid <= 1'b1;
				cand_q.prio  <= prio_q;
				cand_q.age   <= age;
				cand_q.slot  <= idx;
			end else begin
				cand_q <= cand_in;
			end
			if (ctl.wr_en && ctl.wr_slot == idx)
				valid_q <= 1'b1;
			else if (ctl.run_en && hit && last)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_slot == idx) begin
			id_q   <= ctl.wr_id;
			prio_q <= ctl.wr_prio;
			rem_q  <= ctl.wr_rem;
			seq_q  <= ctl.wr_seq;
		end else if (ctl.run_en && hit) begin
			rem_q <= rem_q - pjs_pkg::TIME_W'(1);
		end
	end

	assign cand_out = cand_q;
	assign valid    = valid_q;
	assign rd.id    = hit ? id_q : '0;
	assign rd.last  = hit & last;

endmodule
